[rtl/owrm_pkg.sv]
// Shared types and constants for the outlier-rejecting window mean block.
package owrm_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int WS_W       = 5;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FILT_W     = 24;
    localparam int FRAC_BITS  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;

    localparam logic [WS_W-1:0]  WS_RESET  = 5'd16;
    localparam logic [THR_W-1:0] THR_RESET = 16'hFFFF;

    localparam logic signed [FILT_W-1:0] FILT_MAX = 24'sh7FFFFF;
    localparam logic signed [FILT_W-1:0] FILT_MIN = 24'sh800000;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_BOUND,
        ST_TEST,
        ST_DRAIN,
        ST_DECIDE,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

[rtl/outlier_rejecting_window_mean_core.sv]
// Top level: window cell chain, outlier test sweep, serial mean divider, config and output words.
// The result word follows two rotations of the cell chain and the SAMPLE_BITS+8 step divider;
// the divider is skipped when no sample is kept. One word at a time: the next input is taken in
// the cycle after the result is loaded.
// Reset: window empty, window_size 16, threshold 65535; window cells are not cleared.
module outlier_rejecting_window_mean_core #(
    parameter int WINDOW_DEPTH = owrm_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = owrm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [owrm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [owrm_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   kind,
    input  logic signed [SAMPLE_BITS-1:0]          sample,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [owrm_pkg::FILT_W-1:0]     filtered,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]      kept_count,
    output logic                                   none_kept
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int TW = owrm_pkg::THR_W + CW;
    localparam int LW = (CW > owrm_pkg::WS_W) ? CW : owrm_pkg::WS_W;
    localparam int PW = ((SW > TW + 1) ? SW : TW + 1) + 1;

    owrm_pkg::state_t   state_reg;
    owrm_pkg::state_t   state_next;
    owrm_pkg::cell_op_t cell_op;
    logic               div_start;

    logic [owrm_pkg::WS_W-1:0]  window_size_reg;
    logic [owrm_pkg::THR_W-1:0] threshold_reg;

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [AW-1:0] t_reg;
    logic          t_last;
    logic          t_in_fill;

    logic signed [SAMPLE_BITS-1:0] cell_val [WINDOW_DEPTH];

    logic signed [SW-1:0]          sum_reg;
    logic [TW-1:0]                 tc_reg;
    logic signed [PW-1:0]          lo_reg;
    logic signed [PW-1:0]          hi_reg;
    logic signed [SW-1:0]          prod_reg;
    logic signed [SAMPLE_BITS-1:0] pval_reg;
    logic                          pv_reg;
    logic signed [SW-1:0]          ksum_reg;
    logic [CW-1:0]                 kept_reg;
    logic                          keep;

    logic signed [owrm_pkg::FILT_W-1:0] res_filtered_reg;
    logic [CW-1:0]                      res_kept_reg;
    logic                               res_none_reg;

    logic signed [owrm_pkg::FILT_W-1:0] filtered_reg;
    logic [CW-1:0]                      kept_count_reg;
    logic                               none_kept_reg;
    logic                               out_valid_reg;

    logic                               div_done;
    logic signed [owrm_pkg::FILT_W-1:0] div_result;

    logic          in_take;
    logic          out_load;
    logic [LW-1:0] ws_x;
    logic [LW-1:0] lim_x;
    logic [CW-1:0] lim;
    logic [CW-1:0] base_fill;
    logic [CW-1:0] inc_fill;

    // window cells: cell 0 holds the newest sample
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_DEPTH; gi++)
        begin : g_cell
            localparam int PREV = (gi == 0) ? 0 : gi - 1;
            localparam int NEXT = (gi == WINDOW_DEPTH - 1) ? 0 : gi + 1;
            owrm_cell #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_cell (
                .clk       (clk),
                .op        (cell_op),
                .shift_in  ((gi == 0) ? sample : cell_val[PREV]),
                .rotate_in (cell_val[NEXT]),
                .value     (cell_val[gi])
            );
        end
    endgenerate

    owrm_div #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .CNT_W      (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ksum_reg),
        .den   (kept_reg),
        .done  (div_done),
        .result(div_result)
    );

    always_comb
    begin
        ws_x = LW'(window_size_reg);
        if (window_size_reg == '0)
        begin
            lim_x = LW'(1);
        end
        else if (ws_x > LW'(WINDOW_DEPTH))
        begin
            lim_x = LW'(WINDOW_DEPTH);
        end
        else
        begin
            lim_x = ws_x;
        end
        lim       = CW'(lim_x);
        base_fill = kind ? '0 : fill_reg;
        inc_fill  = (base_fill < CW'(WINDOW_DEPTH)) ? base_fill + 1'b1 : base_fill;
        fill_next = (inc_fill > lim) ? lim : inc_fill;
    end

    assign t_last    = (t_reg == AW'(WINDOW_DEPTH - 1));
    assign t_in_fill = (CW'(t_reg) < fill_reg);
    assign in_take   = in_valid && in_ready;
    assign out_load  = (state_reg == owrm_pkg::ST_OUT) && (!out_valid_reg || out_ready);

    assign keep = pv_reg && (PW'(prod_reg) >= lo_reg) && (PW'(prod_reg) <= hi_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            owrm_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = owrm_pkg::ST_SUM;
                end
            owrm_pkg::ST_SUM:
                if (t_last)
                begin
                    state_next = owrm_pkg::ST_BOUND;
                end
            owrm_pkg::ST_BOUND:
                state_next = owrm_pkg::ST_TEST;
            owrm_pkg::ST_TEST:
                if (t_last)
                begin
                    state_next = owrm_pkg::ST_DRAIN;
                end
            owrm_pkg::ST_DRAIN:
                state_next = owrm_pkg::ST_DECIDE;
            owrm_pkg::ST_DECIDE:
                state_next = (kept_reg == '0) ? owrm_pkg::ST_OUT : owrm_pkg::ST_DIV;
            owrm_pkg::ST_DIV:
                if (div_done)
                begin
                    state_next = owrm_pkg::ST_OUT;
                end
            owrm_pkg::ST_OUT:
                if (!out_valid_reg || out_ready)
                begin
                    state_next = owrm_pkg::ST_IDLE;
                end
            default:
                state_next = owrm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        cell_op   = owrm_pkg::CELL_HOLD;
        div_start = 1'b0;
        case (state_reg)
            owrm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cell_op  = in_valid ? owrm_pkg::CELL_SHIFT : owrm_pkg::CELL_HOLD;
            end
            owrm_pkg::ST_SUM:    cell_op   = owrm_pkg::CELL_ROTATE;
            owrm_pkg::ST_TEST:   cell_op   = owrm_pkg::CELL_ROTATE;
            owrm_pkg::ST_DECIDE: div_start = (kept_reg != '0);
            default:             cell_op   = owrm_pkg::CELL_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= owrm_pkg::ST_IDLE;
            window_size_reg <= owrm_pkg::WS_RESET;
            threshold_reg   <= owrm_pkg::THR_RESET;
            fill_reg        <= '0;
            t_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    owrm_pkg::REG_WINDOW_SIZE:
                        window_size_reg <= cfg_data[owrm_pkg::WS_W-1:0];
                    owrm_pkg::REG_THRESHOLD:
                        threshold_reg <= cfg_data[owrm_pkg::THR_W-1:0];
                    default:
                        ;
                endcase
            end
            if (in_take)
            begin
                fill_reg <= fill_next;
            end
            if ((state_reg == owrm_pkg::ST_SUM) || (state_reg == owrm_pkg::ST_TEST))
            begin
                t_reg <= t_last ? '0 : t_reg + 1'b1;
            end
            else
            begin
                t_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath: sum sweep, bounds, outlier sweep, result capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sum_reg <= '0;
        end
        else if ((state_reg == owrm_pkg::ST_SUM) && t_in_fill)
        begin
            sum_reg <= sum_reg + SW'(cell_val[0]);
        end

        tc_reg <= TW'(threshold_reg) * TW'(fill_reg);

        if (state_reg == owrm_pkg::ST_BOUND)
        begin
            lo_reg   <= PW'(sum_reg) - PW'($signed({1'b0, tc_reg}));
            hi_reg   <= PW'(sum_reg) + PW'($signed({1'b0, tc_reg}));
            ksum_reg <= '0;
            kept_reg <= '0;
        end
        else if (keep)
        begin
            ksum_reg <= ksum_reg + SW'(pval_reg);
            kept_reg <= kept_reg + 1'b1;
        end

        pv_reg   <= (state_reg == owrm_pkg::ST_TEST) && t_in_fill;
        prod_reg <= $signed(SW'({1'b0, fill_reg})) * SW'(cell_val[0]);
        pval_reg <= cell_val[0];

        if ((state_reg == owrm_pkg::ST_DECIDE) && (kept_reg == '0))
        begin
            res_filtered_reg <= '0;
            res_kept_reg     <= '0;
            res_none_reg     <= 1'b1;
        end
        else if ((state_reg == owrm_pkg::ST_DIV) && div_done)
        begin
            res_filtered_reg <= div_result;
            res_kept_reg     <= kept_reg;
            res_none_reg     <= 1'b0;
        end

        if (out_load)
        begin
            filtered_reg   <= res_filtered_reg;
            kept_count_reg <= res_kept_reg;
            none_kept_reg  <= res_none_reg;
        end
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign filtered   = filtered_reg;
    assign kept_count = kept_count_reg;
    assign none_kept  = none_kept_reg;

endmodule

[rtl/owrm_cell.sv]
// One window cell: holds a sample, shifts in from the newer side or rotates from the older side.
module owrm_cell #(
    parameter int SAMPLE_BITS = owrm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  owrm_pkg::cell_op_t            op,
    input  logic signed [SAMPLE_BITS-1:0] shift_in,
    input  logic signed [SAMPLE_BITS-1:0] rotate_in,
    output logic signed [SAMPLE_BITS-1:0] value
);

    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;

    always_comb
    begin
        case (op)
            owrm_pkg::CELL_SHIFT:  value_next = shift_in;
            owrm_pkg::CELL_ROTATE: value_next = rotate_in;
            default:               value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[rtl/owrm_div.sv]
// Bit-serial signed divider for the kept mean, with 8 fraction bits and 24-bit saturation.
module owrm_div #(
    parameter int SAMPLE_BITS = owrm_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W       = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [SAMPLE_BITS+CNT_W-1:0] num,
    input  logic        [CNT_W-1:0]             den,
    output logic                                done,
    output logic signed [owrm_pkg::FILT_W-1:0]  result
);

    localparam int SW  = SAMPLE_BITS + CNT_W;
    localparam int QB  = SAMPLE_BITS + owrm_pkg::FRAC_BITS;
    localparam int NW  = QB + CNT_W;
    localparam int STW = $clog2(QB);
    localparam int EW  = (QB + 1 > owrm_pkg::FILT_W + 1) ? QB + 1 : owrm_pkg::FILT_W + 1;

    localparam logic signed [EW-1:0] MAX_X = EW'(owrm_pkg::FILT_MAX);
    localparam logic signed [EW-1:0] MIN_X = EW'(owrm_pkg::FILT_MIN);

    logic                busy_reg;
    logic                fin_reg;
    logic [STW-1:0]      step_reg;
    logic                neg_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [QB-1:0]       q_reg;
    logic [CNT_W-1:0]    den_reg;

    logic [SW-1:0]       mag;
    logic [NW-1:0]       numer;
    logic [CNT_W:0]      cat;
    logic [CNT_W+1:0]    diff;
    logic                borrow;
    logic [CNT_W-1:0]    rem_next;
    logic [QB-1:0]       q_next;
    logic signed [QB:0]  q_signed;
    logic signed [QB:0]  q_final;
    logic signed [EW-1:0] q_ext;

    always_comb
    begin
        mag      = num[SW-1] ? SW'(-num) : SW'(num);
        numer    = {mag, {owrm_pkg::FRAC_BITS{1'b0}}};
        cat      = {rem_reg, q_reg[QB-1]};
        diff     = {1'b0, cat} - {2'b00, den_reg};
        borrow   = diff[CNT_W+1];
        rem_next = borrow ? cat[CNT_W-1:0] : diff[CNT_W-1:0];
        q_next   = {q_reg[QB-2:0], ~borrow};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            fin_reg <= busy_reg && (step_reg == STW'(QB - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STW'(QB - 1))
                begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[SW-1];
            rem_reg <= numer[NW-1:QB];
            q_reg   <= numer[QB-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    // magnitude quotient back to signed, then clamp to the output range
    always_comb
    begin
        q_signed = $signed({1'b0, q_reg});
        q_final  = neg_reg ? -q_signed : q_signed;
        q_ext    = EW'(q_final);
        if (q_ext > MAX_X)
        begin
            result = owrm_pkg::FILT_MAX;
        end
        else if (q_ext < MIN_X)
        begin
            result = owrm_pkg::FILT_MIN;
        end
        else
        begin
            result = q_ext[owrm_pkg::FILT_W-1:0];
        end
    end

    assign done = fin_reg;

endmodule
